// File: src/hdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hydrodynamic damping package
// Payload types, sequencer codes and saturation helpers for the damping block.
// ----------------------------------------------------------------------------
package hdf_pkg;

   localparam int DIM      = 6;
   localparam int MAT_SIZE = 36;
   localparam int DATA_W   = 32;
   localparam int ACC_W    = 64;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 36;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic REG_WATER_LEVEL = 1'b0;
   localparam logic REG_MATRIX_MODE = 1'b1;

   localparam logic MODE_TWO = 1'b0;
   localparam logic MODE_SIX = 1'b1;

   localparam logic signed [ACC_W-1:0] ROW_LIMIT     = 64'sh0000_0004_0000_0000;
   localparam logic signed [ACC_W-1:0] ROW_LIMIT_NEG = -64'sh0000_0004_0000_0000;

   typedef struct packed {
      logic                     op;
      logic [7:0]               coef_index;
      logic signed [31:0]       coef_value;
      logic signed [31:0]       surge_vel;
      logic signed [31:0]       sway_vel;
      logic signed [31:0]       heave_vel;
      logic signed [31:0]       roll_rate;
      logic signed [31:0]       pitch_rate;
      logic signed [31:0]       yaw_rate;
      logic signed [31:0]       link_height;
      logic [30:0]              box_height;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] torque_x;
      logic signed [31:0] torque_y;
      logic signed [31:0] torque_z;
      logic               saturated;
   } rsp_type;

   // operation carried down the multiply pipeline
   typedef enum logic [2:0] {
      K_VSQ = 3'd0,   // v_j * |v_j|  -> weighted velocity
      K_CV  = 3'd1,   // D0 * v_j     -> row sum
      K_CW  = 3'd2,   // D1 * w_j     -> row sum
      K_CA  = 3'd3,   // Dk * |v_k|   -> weighted entry
      K_MV  = 3'd4,   // entry * v_j  -> row sum
      K_FIN = 3'd5    // row * ratio  -> result
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] row;
      logic [2:0] sel;
      logic       first;
      logic       zero;
   } ctl_type;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_PREP = 12'b0000_0000_0010,
      ST_DIV  = 12'b0000_0000_0100,
      ST_WSQ  = 12'b0000_0000_1000,
      ST_ROW  = 12'b0000_0001_0000,
      ST_MACC = 12'b0000_0010_0000,
      ST_MGAP = 12'b0000_0100_0000,
      ST_MMUL = 12'b0000_1000_0000,
      ST_FGAP = 12'b0001_0000_0000,
      ST_FIN  = 12'b0010_0000_0000,
      ST_WAIT = 12'b0100_0000_0000,
      ST_DONE = 12'b1000_0000_0000
   } state_type;

   function automatic logic ovf32(input logic signed [ACC_W-1:0] x);
      return !((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1]));
   endfunction

   function automatic logic signed [DATA_W-1:0] clip32(input logic signed [ACC_W-1:0] x);
      logic signed [DATA_W-1:0] res;
      if (ovf32(x)) begin
         res = x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         res = x[DATA_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [MUL_B_W-1:0] clamp_row(input logic signed [ACC_W-1:0] x);
      logic signed [MUL_B_W-1:0] res;
      if (x > ROW_LIMIT) begin
         res = ROW_LIMIT[MUL_B_W-1:0];
      end else if (x < ROW_LIMIT_NEG) begin
         res = ROW_LIMIT_NEG[MUL_B_W-1:0];
      end else begin
         res = x[MUL_B_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: src/hydrodynamic_damping_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hydrodynamic damping force
// Six-axis linear/quadratic damping effort from a loadable coefficient store.
// ----------------------------------------------------------------------------
// Coefficient write: the input stays ready. Compute: a setup state follows the transfer,
// and a dry item ends there. A wet item at most half submerged then runs the ratio
// divider (one bit a cycle); the single shared multiplier then runs the two-matrix or
// six-matrix mode sequence (one product a cycle, one bubble per weighted entry,
// pipeline drain, result load); ready returns with valid.
// Reset clears control and the configuration registers; the coefficient store is not cleared.
module hydrodynamic_damping_force_top
   import hdf_pkg::*;
#(
   parameter int MAX_MATRICES = 6,
   parameter int FRAC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH  = MAX_MATRICES * MAT_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int R_W    = FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [31:0] water_level_ff;
   logic               mode_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         water_level_ff <= '0;
         mode_ff        <= MODE_TWO;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_WATER_LEVEL: water_level_ff <= pwdata;
            REG_MATRIX_MODE: mode_ff        <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WATER_LEVEL: prdata = water_level_ff;
         REG_MATRIX_MODE: prdata = {31'd0, mode_ff};
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Input transfer and item registers
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      req_xfer;
   logic      compute_xfer;
   logic      write_xfer;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_xfer     = req_valid && req_ready;
   assign compute_xfer = req_xfer && (req_data.op == OP_COMPUTE);
   assign write_xfer   = req_xfer && (req_data.op == OP_WRITE)
                         && ({1'b0, req_data.coef_index} < 9'(DEPTH));

   logic signed [31:0] vel_ff [DIM];
   logic signed [32:0] depth_ff;   // water level minus link height
   logic [30:0]        height_ff;

   always_ff @(posedge clock) begin
      if (compute_xfer) begin
         vel_ff[0] <= req_data.surge_vel;
         vel_ff[1] <= req_data.sway_vel;
         vel_ff[2] <= req_data.heave_vel;
         vel_ff[3] <= req_data.roll_rate;
         vel_ff[4] <= req_data.pitch_rate;
         vel_ff[5] <= req_data.yaw_rate;
         depth_ff  <= 33'(water_level_ff) - 33'(req_data.link_height);
         height_ff <= req_data.box_height;
      end
   end

   // ------------------------------------------------------------------
   // Coefficient store: one write port, one registered read port
   // ------------------------------------------------------------------
   logic signed [31:0] store [DEPTH];
   logic signed [31:0] rd_ff;
   logic [ADDR_W-1:0]  addr_issue;
   logic               issue;

   always_ff @(posedge clock) begin
      if (write_xfer) begin
         store[req_data.coef_index[ADDR_W-1:0]] <= req_data.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= store[addr_issue];
      end
   end

   // ------------------------------------------------------------------
   // Submerged ratio: setup, then a restoring divider one bit a cycle
   // ------------------------------------------------------------------
   logic             wet;
   logic             half;
   logic [31:0]      num;
   logic [31:0]      den;
   logic             qtop;
   logic [31:0]      rem_ff;
   logic [32:0]      rem_shift;
   logic             rem_ge;
   logic [R_W-1:0]   ratio_ff;
   logic [CNT_W-1:0] div_cnt_ff;

   assign wet       = (depth_ff > 33'sd0);
   assign half      = ({depth_ff[31:0], 1'b0} <= {2'b00, height_ff});
   assign den       = {height_ff, 1'b0};
   assign num       = {1'b0, height_ff} + {depth_ff[30:0], 1'b0};
   assign qtop      = (num >= den);
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, den});

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         rem_ff     <= qtop ? (num - den) : num;
         div_cnt_ff <= CNT_W'(FRAC_BITS - 1);
         if (half) begin
            ratio_ff <= {{(R_W-1){1'b0}}, qtop};
         end else begin
            ratio_ff <= {1'b1, {(R_W-1){1'b0}}};
         end
      end else if (state_ff == ST_DIV) begin
         // subtract when the shifted remainder covers the divisor
         rem_ff     <= rem_ge ? 32'(rem_shift - {1'b0, den}) : rem_shift[31:0];
         ratio_ff   <= {ratio_ff[R_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: in the WSQ, ROW, MACC, MMUL and FIN states, one multiply issued per cycle
   // ------------------------------------------------------------------
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic       sub_ff, sub_in;
   ctl_type    ctl_issue;
   logic [2:0] mat_issue;
   logic [7:0] addr_full;
   logic       v1_ff, v2_ff;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sub_in    = sub_ff;
      issue     = 1'b0;
      mat_issue = 3'd0;
      ctl_issue = '{kind: K_VSQ, row: i_ff, sel: j_ff, first: 1'b0, zero: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (compute_xfer) state_in = ST_PREP;
         end
         ST_PREP: begin
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            sub_in = 1'b0;
            if (!wet) begin
               state_in = ST_IDLE;   // dry: drop the item
            end else if (half) begin
               state_in = ST_DIV;
            end else begin
               state_in = (mode_ff == MODE_SIX) ? ST_MACC : ST_WSQ;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) state_in = (mode_ff == MODE_SIX) ? ST_MACC : ST_WSQ;
         end
         ST_WSQ: begin
            issue          = 1'b1;
            ctl_issue.kind = K_VSQ;
            j_in           = j_ff + 3'd1;
            if (j_ff == 3'(DIM - 1)) begin
               j_in     = '0;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            issue           = 1'b1;
            mat_issue       = {2'b00, sub_ff};
            ctl_issue.kind  = sub_ff ? K_CW : K_CV;
            ctl_issue.first = (j_ff == 3'd0) && !sub_ff;
            sub_in          = !sub_ff;
            if (sub_ff) begin
               j_in = j_ff + 3'd1;
               if (j_ff == 3'(DIM - 1)) begin
                  j_in = '0;
                  i_in = i_ff + 3'd1;
                  if (i_ff == 3'(DIM - 1)) state_in = ST_FGAP;
               end
            end
         end
         ST_MACC: begin
            issue           = 1'b1;
            ctl_issue.kind  = K_CA;
            ctl_issue.sel   = k_ff;
            ctl_issue.first = (k_ff == 3'd0);
            ctl_issue.zero  = ({1'b0, k_ff} >= 4'(MAX_MATRICES));
            mat_issue       = ctl_issue.zero ? 3'd0 : k_ff;
            k_in            = k_ff + 3'd1;
            if (k_ff == 3'(DIM - 1)) begin
               k_in     = '0;
               state_in = ST_MGAP;
            end
         end
         ST_MGAP: begin
            state_in = ST_MMUL;   // let the weighted entry settle
         end
         ST_MMUL: begin
            issue           = 1'b1;
            ctl_issue.kind  = K_MV;
            ctl_issue.first = (j_ff == 3'd0);
            state_in        = ST_MACC;
            j_in            = j_ff + 3'd1;
            if (j_ff == 3'(DIM - 1)) begin
               j_in = '0;
               i_in = i_ff + 3'd1;
               if (i_ff == 3'(DIM - 1)) state_in = ST_FGAP;
            end
         end
         ST_FGAP: begin
            i_in     = '0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            issue          = 1'b1;
            ctl_issue.kind = K_FIN;
            i_in           = i_ff + 3'd1;
            if (i_ff == 3'(DIM - 1)) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!v1_ff && !v2_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // the store column is always the matrix column j
   assign addr_full  = 8'(mat_issue) * 8'(MAT_SIZE) + 8'(ctl_issue.row) * 8'(DIM)
                       + 8'(j_ff);
   assign addr_issue = addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         sub_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         sub_ff   <= sub_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline: read -> multiply -> accumulate
   // ------------------------------------------------------------------
   ctl_type                     ctl1_ff, ctl2_ff;
   logic signed [MUL_P_W-1:0]   prod_ff;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   prod_in;
   logic signed [31:0]          v_sel;
   logic signed [32:0]          v_ext;
   logic signed [32:0]          v_abs;
   logic signed [31:0]          coef;
   logic signed [ACC_W-1:0]     m_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     row_ff [DIM];
   logic signed [31:0]          w_ff [DIM];
   logic signed [31:0]          out_ff [DIM];

   assign v_sel = vel_ff[ctl1_ff.sel];
   assign v_ext = 33'(v_sel);
   assign v_abs = v_ext[32] ? -v_ext : v_ext;
   assign coef  = ctl1_ff.zero ? 32'sd0 : rd_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl1_ff.kind)
         K_VSQ: begin
            mul_a = v_ext;
            mul_b = MUL_B_W'(v_abs);
         end
         K_CV: begin
            mul_a = MUL_A_W'(coef);
            mul_b = MUL_B_W'(v_sel);
         end
         K_CW: begin
            mul_a = MUL_A_W'(coef);
            mul_b = MUL_B_W'(w_ff[ctl1_ff.sel]);
         end
         K_CA: begin
            mul_a = MUL_A_W'(coef);
            mul_b = MUL_B_W'(v_abs);
         end
         K_MV: begin
            mul_a = MUL_A_W'(clip32(m_ff));
            mul_b = MUL_B_W'(v_sel);
         end
         K_FIN: begin
            mul_a = signed'(MUL_A_W'(ratio_ff));
            mul_b = clamp_row(row_ff[ctl1_ff.row]);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl1_ff <= ctl_issue;
      ctl2_ff <= ctl1_ff;
      prod_ff <= prod_in;
   end

   // floored product and its uses
   logic signed [MUL_P_W-1:0] shifted;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   neg_term;
   logic signed [ACC_W-1:0]   acc_in;

   assign shifted  = prod_ff >>> FRAC_BITS;
   assign term     = shifted[ACC_W-1:0];
   assign neg_term = -term;
   assign acc_in   = ctl2_ff.first ? term : (acc_ff + term);

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         case (ctl2_ff.kind)
            K_VSQ: w_ff[ctl2_ff.sel] <= clip32(term);
            K_CV, K_CW, K_MV: begin
               acc_ff              <= acc_in;
               row_ff[ctl2_ff.row] <= acc_in;
            end
            K_CA:  m_ff <= ctl2_ff.first ? term : (m_ff + term);
            K_FIN: out_ff[ctl2_ff.row] <= clip32(neg_term);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Saturation flag
   // ------------------------------------------------------------------
   logic flag_ff, flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (v1_ff && (ctl1_ff.kind == K_MV) && ovf32(m_ff)) flag_in = 1'b1;
      if (v2_ff && (ctl2_ff.kind == K_VSQ) && ovf32(term)) flag_in = 1'b1;
      if (v2_ff && (ctl2_ff.kind == K_FIN) && ovf32(neg_term)) flag_in = 1'b1;
      if (compute_xfer) flag_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: hold until the transfer completes
   // ------------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    rsp_load;

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.force_x   <= out_ff[0];
         rsp_data_ff.force_y   <= out_ff[1];
         rsp_data_ff.force_z   <= out_ff[2];
         rsp_data_ff.torque_x  <= out_ff[3];
         rsp_data_ff.torque_y  <= out_ff[4];
         rsp_data_ff.torque_z  <= out_ff[5];
         rsp_data_ff.saturated <= flag_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      compute_xfer |=> !req_ready)
      else $error("input accepted while a compute item is in flight");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("accumulate stage fired without a multiply");

endmodule
